// File: rtl/cks_pkg.sv
package cks_pkg;

    // Default width of the internal send schedule
    localparam int TIME_BITS_DEFAULT = 32;

    // Widths of the ports, payload fields and internal counters
    localparam int NOW_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int PERIOD_W = 16;
    localparam int NIBBLE_W = 4;
    localparam int PHASE_W  = 3;
    localparam int ATT_W    = 9;
    localparam int SIL_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUICK_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_COMMAND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_COMMAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_COMMAND     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONN_STATUS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_STATUS      = 3'd7;

    // Link phase codes
    localparam logic [PHASE_W-1:0] PH_INIT         = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CLEARFAULT   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DISCONNECTED = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CONNECTING   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CONNECTED1   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CONNECTED    = 3'd5;

    // Item kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_MESSAGE = 1'b1;

    // Retry limits and saturation points
    localparam logic [ATT_W-1:0] CONNECT_TRIES = 9'd300;
    localparam logic [ATT_W-1:0] FAULT_TRIES   = 9'd4;
    localparam logic [ATT_W-1:0] ATTEMPT_MAX   = 9'd511;
    localparam logic [SIL_W-1:0] SILENCE_MAX   = 16'hffff;

    // Reset values of the configuration registers
    localparam logic [PERIOD_W-1:0] KEEPALIVE_RST = 16'd128;
    localparam logic [PERIOD_W-1:0] QUICK_RST     = 16'd16;
    localparam logic [PERIOD_W-1:0] SILENCE_RST   = 16'd64;
    localparam logic [BYTE_W-1:0]   RESET_CMD_RST = 8'd128;
    localparam logic [BYTE_W-1:0]   CONN_CMD_RST  = 8'd64;
    localparam logic [BYTE_W-1:0]   DISC_CMD_RST  = 8'd0;
    localparam logic [NIBBLE_W-1:0] CONN_STS_RST  = 4'd5;
    localparam logic [NIBBLE_W-1:0] DISC_STS_RST  = 4'd0;

    typedef struct packed {
        logic [PERIOD_W-1:0] keepalive_period;
        logic [PERIOD_W-1:0] quick_period;
        logic [PERIOD_W-1:0] silence_limit;
        logic [BYTE_W-1:0]   reset_command;
        logic [BYTE_W-1:0]   connect_command;
        logic [BYTE_W-1:0]   disconnect_command;
        logic [NIBBLE_W-1:0] connected_status;
        logic [NIBBLE_W-1:0] disconnected_status;
    } cks_cfg_t;

    typedef struct packed {
        logic              kind;
        logic [NOW_W-1:0]  time_now;
        logic [BYTE_W-1:0] status_byte;
        logic [BYTE_W-1:0] fault_byte;
        logic              want_connect;
    } cks_item_t;

    // Input stage to core: a held word and its valid
    typedef struct packed {
        logic      valid;
        cks_item_t item;
    } cks_stage_t;

    typedef struct packed {
        logic               send_now;
        logic [BYTE_W-1:0]  command_code;
        logic               no_response;
        logic [PHASE_W-1:0] link_phase;
        logic [BYTE_W-1:0]  last_status;
    } cks_result_t;

endpackage

// File: rtl/cks_cfg_regs.sv
module cks_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cks_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cks_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output cks_pkg::cks_cfg_t               cfg
);
    import cks_pkg::*;

    cks_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.keepalive_period    <= KEEPALIVE_RST;
            cfg_reg.quick_period        <= QUICK_RST;
            cfg_reg.silence_limit       <= SILENCE_RST;
            cfg_reg.reset_command       <= RESET_CMD_RST;
            cfg_reg.connect_command     <= CONN_CMD_RST;
            cfg_reg.disconnect_command  <= DISC_CMD_RST;
            cfg_reg.connected_status    <= CONN_STS_RST;
            cfg_reg.disconnected_status <= DISC_STS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KEEPALIVE_PERIOD: cfg_reg.keepalive_period <= cfg_wdata;
                CFG_QUICK_PERIOD:     cfg_reg.quick_period     <= cfg_wdata;
                CFG_SILENCE_LIMIT:    cfg_reg.silence_limit    <= cfg_wdata;
                CFG_RESET_COMMAND:    cfg_reg.reset_command    <= cfg_wdata[BYTE_W-1:0];
                CFG_CONNECT_COMMAND:  cfg_reg.connect_command  <= cfg_wdata[BYTE_W-1:0];
                CFG_DISC_COMMAND:     cfg_reg.disconnect_command <= cfg_wdata[BYTE_W-1:0];
                CFG_CONN_STATUS:      cfg_reg.connected_status <= cfg_wdata[NIBBLE_W-1:0];
                CFG_DISC_STATUS:      cfg_reg.disconnected_status <= cfg_wdata[NIBBLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/cks_in_stage.sv
module cks_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cks_pkg::cks_item_t  s_item,
    input  logic                take,
    output cks_pkg::cks_stage_t stage
);
    import cks_pkg::*;

    logic      valid_reg;
    cks_item_t item_reg;

    // Refill when empty or when the held word moves on this cycle
    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: rtl/cks_core.sv
module cks_core #(
    parameter int TIME_BITS = cks_pkg::TIME_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cks_pkg::cks_cfg_t    cfg,
    input  cks_pkg::cks_stage_t  stage,
    output logic                 take,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cks_pkg::cks_result_t result
);
    import cks_pkg::*;

    localparam int NOW_KEEP = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [BYTE_W-1:0]    cmd_reg, cmd_next;
    logic [ATT_W-1:0]     attempt_reg, attempt_next;
    logic [TIME_BITS-1:0] nst_reg, nst_next;
    logic [SIL_W-1:0]     sil_reg, sil_next;
    logic                 silent_reg, silent_next;
    logic [BYTE_W-1:0]    rx_reg, rx_next;
    logic                 send;

    logic                 out_valid_reg;
    cks_result_t          result_reg;

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] due_gap;
    logic                 due;
    logic [TIME_BITS-1:0] keep_time;
    logic [TIME_BITS-1:0] quick_time;
    logic [SIL_W-1:0]     sil_inc;
    logic [ATT_W-1:0]     attempt_inc;
    logic                 nibble_ok;

    assign take = stage.valid && (!out_valid_reg || m_ready);

    // Fold the tick counter into the schedule width
    always_comb begin
        now = '0;
        now[NOW_KEEP-1:0] = stage.item.time_now[NOW_KEEP-1:0];
    end

    assign keep_time   = now + TIME_BITS'(cfg.keepalive_period);
    assign quick_time  = now + TIME_BITS'(cfg.quick_period);
    assign due_gap     = nst_reg - now;
    assign due         = (due_gap == '0) || due_gap[TIME_BITS-1];
    assign sil_inc     = (sil_reg == SILENCE_MAX) ? sil_reg : sil_reg + 1'b1;
    assign attempt_inc = (attempt_reg == ATTEMPT_MAX) ? attempt_reg : attempt_reg + 1'b1;
    assign nibble_ok   = (stage.item.status_byte[NIBBLE_W-1:0] == cfg.connected_status);

    always_comb begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        attempt_next = attempt_reg;
        nst_next     = nst_reg;
        sil_next     = sil_reg;
        silent_next  = silent_reg;
        rx_next      = rx_reg;
        send         = 1'b0;

        if (stage.item.kind == KIND_TICK) begin
            sil_next = sil_inc;
            if (sil_inc >= cfg.silence_limit) begin
                silent_next = 1'b1;
            end
            if (phase_reg == PH_INIT) begin
                nst_next     = keep_time;
                cmd_next     = cfg.reset_command;
                attempt_next = '0;
                send         = 1'b1;
                phase_next   = PH_CLEARFAULT;
            end else if (due) begin
                nst_next = keep_time;
                send     = 1'b1;
            end
        end else begin
            sil_next    = '0;
            silent_next = 1'b0;
            rx_next     = stage.item.status_byte;
            nst_next    = quick_time;
            if (!stage.item.want_connect) begin
                cmd_next   = cfg.reset_command;
                phase_next = PH_CLEARFAULT;
            end else begin
                unique case (phase_reg)
                    PH_CLEARFAULT: begin
                        if ((stage.item.fault_byte != '0) && (attempt_inc > FAULT_TRIES)) begin
                            // Fault with the attempt count past the retry limit: restart the count, stay
                            attempt_next = '0;
                        end else begin
                            cmd_next     = cfg.disconnect_command;
                            attempt_next = '0;
                            phase_next   = PH_DISCONNECTED;
                        end
                    end
                    PH_CONNECTING: begin
                        cmd_next = cfg.connect_command;
                        if (!nibble_ok) begin
                            attempt_next = attempt_inc;
                            if (attempt_inc > CONNECT_TRIES) begin
                                phase_next = PH_INIT;
                            end
                        end else begin
                            phase_next = PH_CONNECTED1;
                        end
                    end
                    PH_CONNECTED1:   phase_next = PH_CONNECTED;
                    PH_CONNECTED: begin
                        if (!nibble_ok) begin
                            phase_next = PH_DISCONNECTED;
                        end
                    end
                    PH_DISCONNECTED: phase_next = PH_CONNECTING;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_INIT;
            cmd_reg     <= '0;
            attempt_reg <= '0;
            nst_reg     <= '0;
            sil_reg     <= '0;
            silent_reg  <= 1'b1;
            rx_reg      <= '0;
        end else if (take) begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            attempt_reg <= attempt_next;
            nst_reg     <= nst_next;
            sil_reg     <= sil_next;
            silent_reg  <= silent_next;
            rx_reg      <= rx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg.send_now     <= send;
            result_reg.command_code <= cmd_next;
            result_reg.no_response  <= silent_next;
            result_reg.link_phase   <= phase_next;
            result_reg.last_status  <= rx_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = result_reg;

endmodule

// File: rtl/contactor_keepalive_sequencer.sv
// Contactor keepalive sequencer.
// Input channel (s_valid/s_ready): one word per event. s_kind low is a time
// tick carrying the free-running tick count in s_time_now; s_kind high is a
// status message from the contactor (s_status_byte, s_fault_byte) together
// with the host's s_want_connect request.
// Result channel (m_valid/m_ready): one word per input word, in order. It
// flags whether the keepalive command goes out now (m_send_now), gives the
// current command byte, the no-response flag, the link phase and the last
// status byte seen.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (periods,
// silence limit, command bytes, status nibbles). Write only while idle.
// Timing: an accepted word is held in the input register; the state update
// and the result register load happen when the core takes it from there,
// so the input and result registers lie between a word and its result.
// One word per cycle is sustained while m_ready stays high.
// Reset (aresetn low, synchronous): phase init, command and counters zero,
// no-response set, registers back to their defaults, both channels empty.
// Stall: while m_ready is low the result holds; one more word waits in the
// input register, then s_ready drops until the result is taken.
module contactor_keepalive_sequencer #(
    parameter int TIME_BITS = cks_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [cks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cks_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [cks_pkg::NOW_W-1:0]         s_time_now,
    input  logic [cks_pkg::BYTE_W-1:0]        s_status_byte,
    input  logic [cks_pkg::BYTE_W-1:0]        s_fault_byte,
    input  logic                              s_want_connect,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_send_now,
    output logic [cks_pkg::BYTE_W-1:0]        m_command_code,
    output logic                              m_no_response,
    output logic [cks_pkg::PHASE_W-1:0]       m_link_phase,
    output logic [cks_pkg::BYTE_W-1:0]        m_last_status
);
    import cks_pkg::*;

    cks_cfg_t    cfg;
    cks_item_t   s_item;
    cks_stage_t  stage;
    cks_result_t result;
    logic        take;

    // Gather the input word
    assign s_item.kind         = s_kind;
    assign s_item.time_now     = s_time_now;
    assign s_item.status_byte  = s_status_byte;
    assign s_item.fault_byte   = s_fault_byte;
    assign s_item.want_connect = s_want_connect;

    cks_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Hold one word ahead of the sequencer
    cks_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .take    (take),
        .stage   (stage)
    );

    // Advance the link sequence and load the result register
    cks_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .stage   (stage),
        .take    (take),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .result  (result)
    );

    // Spread the result word over the ports
    assign m_send_now     = result.send_now;
    assign m_command_code = result.command_code;
    assign m_no_response  = result.no_response;
    assign m_link_phase   = result.link_phase;
    assign m_last_status  = result.last_status;

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cks_pkg::*;

    // Longest run of cycles with no word moving on either channel before the
    // run is declared hung. The longest legal quiet stretch is the forced
    // receiver hold-off plus a register write pass, well under this figure.
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 240;

    // Receiver stall patterns
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_RING} rx_mode_t;

    // One row of the directed script: the word to send, and optionally the
    // result typed in by hand when it can be read straight off the rules.
    typedef struct {
        cks_item_t   word;
        bit          known;
        cks_result_t answer;
    } script_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_kind;
    logic [NOW_W-1:0]      s_time_now;
    logic [BYTE_W-1:0]     s_status_byte;
    logic [BYTE_W-1:0]     s_fault_byte;
    logic                  s_want_connect;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_send_now;
    logic [BYTE_W-1:0]     m_command_code;
    logic                  m_no_response;
    logic [PHASE_W-1:0]    m_link_phase;
    logic [BYTE_W-1:0]     m_last_status;

    always #5 aclk = ~aclk;

    contactor_keepalive_sequencer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_time_now     (s_time_now),
        .s_status_byte  (s_status_byte),
        .s_fault_byte   (s_fault_byte),
        .s_want_connect (s_want_connect),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_send_now     (m_send_now),
        .m_command_code (m_command_code),
        .m_no_response  (m_no_response),
        .m_link_phase   (m_link_phase),
        .m_last_status  (m_last_status)
    );

    // ------------------------------------------------------------------
    // Link sequencer mirror: register file and state as they stand after
    // every accepted word. Values here are the reset values of the block.
    // ------------------------------------------------------------------
    cks_cfg_t regs = '{KEEPALIVE_RST, QUICK_RST, SILENCE_RST, RESET_CMD_RST,
                       CONN_CMD_RST, DISC_CMD_RST, CONN_STS_RST, DISC_STS_RST};

    logic [PHASE_W-1:0] lk_phase     = PH_INIT;
    logic [BYTE_W-1:0]  lk_cmd       = '0;
    logic [ATT_W-1:0]   lk_attempts  = '0;
    logic [NOW_W-1:0]   lk_next_send = '0;
    logic [SIL_W-1:0]   lk_silence   = '0;
    logic               lk_silent    = 1'b1;
    logic [BYTE_W-1:0]  lk_rx_status = '0;

    // Results owed by the block, oldest first
    cks_result_t pending_results[$];

    int               mismatches   = 0;
    int               words_sent   = 0;
    int               burst_left   = 0;
    int               hold_ask     = 0;
    int               quiet_cycles = 0;
    logic [NOW_W-1:0] clock_now    = '0;

    // Directed script, sent with the reset register values. The opening rows
    // walk the whole connect sequence by hand; later rows cover the fault
    // retry count in clear-fault and schedule checks across the time wrap.
    script_row_t script [25] = '{
        // message while still in init: only silence, status and schedule move
        '{'{KIND_MESSAGE, 32'd0,   8'h5a, 8'h00, 1'b1}, 1'b1,
          '{1'b0, 8'h00, 1'b0, PH_INIT, 8'h5a}},
        // first tick sends the reset command at once
        '{'{KIND_TICK, 32'd16,     8'h00, 8'h00, 1'b0}, 1'b1,
          '{1'b1, 8'h80, 1'b0, PH_CLEARFAULT, 8'h5a}},
        '{'{KIND_TICK, 32'd100,    8'hff, 8'hff, 1'b1}, 1'b1,
          '{1'b0, 8'h80, 1'b0, PH_CLEARFAULT, 8'h5a}},
        // exactly due: send again
        '{'{KIND_TICK, 32'd144,    8'h00, 8'h00, 1'b0}, 1'b1,
          '{1'b1, 8'h80, 1'b0, PH_CLEARFAULT, 8'h5a}},
        '{'{KIND_MESSAGE, 32'd150, 8'h00, 8'h00, 1'b1}, 1'b1,
          '{1'b0, 8'h00, 1'b0, PH_DISCONNECTED, 8'h00}},
        '{'{KIND_MESSAGE, 32'd151, 8'ha3, 8'h00, 1'b1}, 1'b1,
          '{1'b0, 8'h00, 1'b0, PH_CONNECTING, 8'ha3}},
        // connected nibble under a nonzero high nibble
        '{'{KIND_MESSAGE, 32'd152, 8'hf5, 8'h00, 1'b1}, 1'b1,
          '{1'b0, 8'h40, 1'b0, PH_CONNECTED1, 8'hf5}},
        '{'{KIND_MESSAGE, 32'd153, 8'h05, 8'h00, 1'b1}, 1'b1,
          '{1'b0, 8'h40, 1'b0, PH_CONNECTED, 8'h05}},
        '{'{KIND_MESSAGE, 32'd154, 8'h15, 8'h00, 1'b1}, 1'b1,
          '{1'b0, 8'h40, 1'b0, PH_CONNECTED, 8'h15}},
        // connected drop
        '{'{KIND_MESSAGE, 32'd155, 8'h06, 8'h00, 1'b1}, 1'b1,
          '{1'b0, 8'h40, 1'b0, PH_DISCONNECTED, 8'h06}},
        // connect withdrawn: back to clear-fault with the reset command
        '{'{KIND_MESSAGE, 32'd156, 8'hff, 8'hff, 1'b0}, 1'b1,
          '{1'b0, 8'h80, 1'b0, PH_CLEARFAULT, 8'hff}},
        // single fault count is below the retry limit: move on
        '{'{KIND_MESSAGE, 32'd157, 8'h00, 8'h01, 1'b1}, 1'b1,
          '{1'b0, 8'h00, 1'b0, PH_DISCONNECTED, 8'h00}},
        '{'{KIND_MESSAGE, 32'd158, 8'h01, 8'h00, 1'b1}, 1'b1,
          '{1'b0, 8'h00, 1'b0, PH_CONNECTING, 8'h01}},
        // build up the attempt count while connecting
        '{'{KIND_MESSAGE, 32'd159, 8'h12, 8'h00, 1'b1}, 1'b0, '0},
        '{'{KIND_MESSAGE, 32'd160, 8'h2f, 8'h00, 1'b1}, 1'b0, '0},
        '{'{KIND_MESSAGE, 32'd161, 8'h30, 8'h00, 1'b1}, 1'b0, '0},
        '{'{KIND_MESSAGE, 32'd162, 8'h4c, 8'h00, 1'b1}, 1'b0, '0},
        '{'{KIND_MESSAGE, 32'd163, 8'h07, 8'h00, 1'b1}, 1'b0, '0},
        // carry that count into clear-fault, then fault past the limit
        '{'{KIND_MESSAGE, 32'd164, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{KIND_MESSAGE, 32'd165, 8'h00, 8'h80, 1'b1}, 1'b0, '0},
        '{'{KIND_MESSAGE, 32'd166, 8'h00, 8'h80, 1'b1}, 1'b0, '0},
        // ticks across the 32-bit wrap and half a range away
        '{'{KIND_TICK, 32'hffff_fff0, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{KIND_TICK, 32'hffff_ffff, 8'hff, 8'hff, 1'b1}, 1'b0, '0},
        '{'{KIND_TICK, 32'h0000_0100, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{KIND_TICK, 32'h7fff_ffff, 8'h00, 8'h00, 1'b0}, 1'b0, '0}
    };

    function automatic void bump_attempts();
        if (lk_attempts != ATTEMPT_MAX) lk_attempts++;
    endfunction

    // Advance the mirror by one accepted word and return the result it owes.
    function automatic cks_result_t next_link_result(cks_item_t w);
        logic             send = 1'b0;
        logic             stay = 1'b0;
        logic [NOW_W-1:0] lead;
        if (w.kind == KIND_TICK) begin
            if (lk_silence != SILENCE_MAX) lk_silence++;
            if (lk_silence >= regs.silence_limit) lk_silent = 1'b1;
            // due when the scheduled time is now or behind, read as signed
            lead = lk_next_send - w.time_now;
            if (lk_phase == PH_INIT) begin
                lk_cmd       = regs.reset_command;
                lk_attempts  = '0;
                lk_phase     = PH_CLEARFAULT;
                lk_next_send = w.time_now + regs.keepalive_period;
                send         = 1'b1;
            end else if (lead == '0 || lead[NOW_W-1]) begin
                lk_next_send = w.time_now + regs.keepalive_period;
                send         = 1'b1;
            end
        end else begin
            lk_silence   = '0;
            lk_silent    = 1'b0;
            lk_rx_status = w.status_byte;
            if (!w.want_connect) begin
                lk_cmd   = regs.reset_command;
                lk_phase = PH_CLEARFAULT;
            end else begin
                case (lk_phase)
                    PH_CLEARFAULT: begin
                        if (w.fault_byte != '0) begin
                            bump_attempts();
                            if (lk_attempts > FAULT_TRIES) begin
                                lk_attempts = '0;
                                stay        = 1'b1;
                            end
                        end
                        if (!stay) begin
                            lk_cmd      = regs.disconnect_command;
                            lk_attempts = '0;
                            lk_phase    = PH_DISCONNECTED;
                        end
                    end
                    PH_CONNECTING: begin
                        lk_cmd = regs.connect_command;
                        if (w.status_byte[NIBBLE_W-1:0] != regs.connected_status) begin
                            bump_attempts();
                            if (lk_attempts > CONNECT_TRIES) lk_phase = PH_INIT;
                        end else begin
                            lk_phase = PH_CONNECTED1;
                        end
                    end
                    PH_CONNECTED1: lk_phase = PH_CONNECTED;
                    PH_CONNECTED: begin
                        if (w.status_byte[NIBBLE_W-1:0] != regs.connected_status)
                            lk_phase = PH_DISCONNECTED;
                    end
                    PH_DISCONNECTED: lk_phase = PH_CONNECTING;
                    default: ;
                endcase
            end
            lk_next_send = w.time_now + regs.quick_period;
        end
        return '{send, lk_cmd, lk_silent, lk_phase, lk_rx_status};
    endfunction

    task automatic report(string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Offer one word and hold it until the block takes it. The sender runs
    // in bursts: when a burst is used up, usually drop valid for a random gap first.
    task automatic put_word(cks_item_t word, bit known = 1'b0, cks_result_t answer = '0);
        cks_result_t mirror_res;
        int          gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_kind         <= word.kind;
        s_time_now     <= word.time_now;
        s_status_byte  <= word.status_byte;
        s_fault_byte   <= word.fault_byte;
        s_want_connect <= word.want_connect;
        do @(posedge aclk); while (!s_ready);
        mirror_res = next_link_result(word);
        pending_results.push_back(known ? answer : mirror_res);
        words_sent++;
    endtask

    // Advance the tick counter and send a tick; the message-only fields
    // carry noise, which the block must ignore.
    task automatic put_tick(int unsigned step);
        clock_now += step;
        put_word('{KIND_TICK, clock_now, 8'($urandom), 8'($urandom), 1'($urandom)});
    endtask

    task automatic put_msg(logic [7:0] status, logic [7:0] fault, logic want);
        clock_now += $urandom_range(0, 2);
        put_word('{KIND_MESSAGE, clock_now, status, fault, want});
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_idle();
        s_valid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write all eight registers, one per cycle. Narrow registers get junk in
    // the unused upper bits of the write data, which the block must drop.
    task automatic program_regs(cks_cfg_t c);
        logic [CFG_IDX_W-1:0]  idx [8];
        logic [CFG_DATA_W-1:0] val [8];
        idx = '{CFG_KEEPALIVE_PERIOD, CFG_QUICK_PERIOD, CFG_SILENCE_LIMIT,
                CFG_RESET_COMMAND, CFG_CONNECT_COMMAND, CFG_DISC_COMMAND,
                CFG_CONN_STATUS, CFG_DISC_STATUS};
        val = '{c.keepalive_period, c.quick_period, c.silence_limit,
                {8'($urandom), c.reset_command},
                {8'($urandom), c.connect_command},
                {8'($urandom), c.disconnect_command},
                {12'($urandom), c.connected_status},
                {12'($urandom), c.disconnected_status}};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        regs = c;
    endtask

    // Push the link into connecting and keep it there with non-connected
    // statuses until the retry count runs out and the phase falls to init.
    task automatic run_timeout();
        put_tick(1);
        repeat (310)
            put_msg({4'($urandom), regs.connected_status ^ 4'($urandom_range(1, 15))},
                    8'h00, 1'b1);
    endtask

    // Random traffic, mostly well-formed: tick runs, connect sequences that
    // usually report connected, withdrawn connects, fault bursts with connect
    // requested, and some plain noise words.
    task automatic run_traffic(int count);
        int         goal;
        int         pick;
        int         len;
        logic [3:0] nib;
        goal = words_sent + count;
        while (words_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                len = $urandom_range(1, 12);
                // mostly small steps; now and then a jump anywhere in the range
                repeat (len)
                    put_tick(($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 24));
            end else if (pick < 72) begin
                len = $urandom_range(3, 10);
                repeat (len) begin
                    if ($urandom_range(0, 4) == 0) begin
                        put_tick($urandom_range(0, 8));
                    end else begin
                        nib = ($urandom_range(0, 9) < 6) ? regs.connected_status
                                                         : 4'($urandom);
                        put_msg({4'($urandom), nib},
                                ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00, 1'b1);
                    end
                end
            end else if (pick < 80) begin
                put_msg(8'($urandom), 8'($urandom), 1'b0);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 7))
                    put_msg(8'($urandom), 8'($urandom_range(1, 255)), 1'b1);
            end else begin
                put_word('{1'($urandom), 32'($urandom), 8'($urandom), 8'($urandom),
                           1'($urandom)});
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each taken result word against the oldest
    // owed one, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        cks_result_t owed;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report("result word with none pending");
            end else begin
                owed = pending_results.pop_front();
                check_field("send_now",     8'(m_send_now),     8'(owed.send_now));
                check_field("command_code", m_command_code,     owed.command_code);
                check_field("no_response",  8'(m_no_response),  8'(owed.no_response));
                check_field("link_phase",   8'(m_link_phase),   8'(owed.link_phase));
                check_field("last_status",  m_last_status,      owed.last_status);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which no word moves on either channel.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switch between stall patterns after runs of random length,
    // including open stretches. On request, hold ready low for a long run
    // counted here, so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    initial begin : result_drain
        rx_mode_t   mode      = RX_OPEN;
        int         mode_left = 0;
        int         served    = 0;
        logic [7:0] ring      = 8'b1011_0010;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (served != hold_ask) begin
                served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                    ring      = 8'($urandom);
                end
                mode_left--;
                ring = {ring[6:0], ring[7]};
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ring[0];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        cks_cfg_t pick;
        // drive every input to a known value before reset lets go
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_kind         = KIND_TICK;
        s_time_now     = '0;
        s_status_byte  = '0;
        s_fault_byte   = '0;
        s_want_connect = 1'b0;
        pick           = regs;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the reset register values
        foreach (script[i]) put_word(script[i].word, script[i].known, script[i].answer);
        wait_idle();

        // Random part, one register setting per pass. The first three passes
        // take the extremes: all high, all low, and zero periods with a zero
        // silence limit (every tick flags no-response, every send is due).
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: pick = '{16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff, 4'hf, 4'hf};
                1: pick = '{16'd1, 16'd1, 16'd1, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0};
                2: pick = '{16'd0, 16'd0, 16'd0, 8'($urandom), 8'($urandom), 8'($urandom),
                            4'($urandom), 4'($urandom)};
                3: pick = '{16'd3, 16'd2, 16'd2, 8'($urandom), 8'($urandom), 8'($urandom),
                            4'($urandom), 4'($urandom)};
                default: begin
                    pick.keepalive_period    = 16'($urandom_range(1, 300));
                    pick.quick_period        = 16'($urandom_range(1, 60));
                    pick.silence_limit       = 16'($urandom_range(1, 100));
                    pick.reset_command       = 8'($urandom);
                    pick.connect_command     = 8'($urandom);
                    pick.disconnect_command  = 8'($urandom);
                    pick.connected_status    = 4'($urandom);
                    pick.disconnected_status = 4'($urandom);
                end
            endcase
            program_regs(pick);
            clock_now = $urandom;
            if (p == 1) begin
                // back-pressure: receiver holds off while the sender keeps
                // offering a gap-free burst
                hold_ask++;
                burst_left = 64;
                repeat (64) put_tick($urandom_range(0, 4));
            end
            if (p == 2 || p == 5) run_timeout();
            run_traffic(70);
            // pause the sender until every owed result is in
            wait_idle();
            run_traffic(70);
            wait_idle();
        end

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: files.f
rtl/cks_pkg.sv
rtl/cks_cfg_regs.sv
rtl/cks_in_stage.sv
rtl/cks_core.sv
rtl/contactor_keepalive_sequencer.sv
test/testbench.sv
